### rtl/nbbsr_pkg.sv
// Package: types, codes and geometry constants for the bad-block skipping NAND reader.
package nbbsr_pkg;

  localparam int WORD_W          = 32;
  localparam int PAGE_W          = 21;
  localparam int BAD_W           = 6;
  localparam int MAX_BAD_W       = 5;
  localparam int CFG_INDEX_W     = 2;

  localparam int PAGE_SHIFT      = 11;
  localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;
  localparam int BLOCK_SHIFT     = 6;
  localparam int PAGES_PER_BLOCK = 1 << BLOCK_SHIFT;

  localparam logic [7:0] ERASED_MARK = 8'hff;
  localparam logic [MAX_BAD_W-1:0] MAX_BAD_RESET = 5'd16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_OFFSET   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_LEN       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BAD_BLOCKS = 2'd2;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_MARKER = 2'd1,
    REQ_PAGE   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ACT_CHECK   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_DONE    = 3'd2,
    ACT_FAIL    = 3'd3,
    ACT_IGNORED = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MARKER = 2'd1,
    PH_PAGE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0]    image_offset;
    logic [WORD_W-1:0]    read_len;
    logic [MAX_BAD_W-1:0] max_bad_blocks;
  } cfg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] phys_page;
    logic [WORD_W-1:0] logical_bytes;
    logic [WORD_W-1:0] remaining_bytes;
    logic [BAD_W-1:0]  bad_count;
    logic [WORD_W-1:0] dest_bytes;
    phase_t            phase;
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [PAGE_W-1:0] page_number;
    logic [WORD_W-1:0] address_word;
    logic [WORD_W-1:0] dest_offset;
  } result_t;

endpackage

### rtl/nbbsr_step.sv
// Next-state and command logic for one request beat.
module nbbsr_step (
  input  nbbsr_pkg::cfg_t    cfg,
  input  nbbsr_pkg::state_t  cur,
  input  logic [1:0]         req_type,
  input  logic [7:0]         marker_byte,
  output nbbsr_pkg::state_t  nxt,
  output nbbsr_pkg::result_t res
);

  localparam int PW     = nbbsr_pkg::PAGE_W;
  localparam int WW     = nbbsr_pkg::WORD_W;
  localparam int BS     = nbbsr_pkg::BLOCK_SHIFT;
  localparam int PS     = nbbsr_pkg::PAGE_SHIFT;
  localparam int STEP_W = BS + 1;
  localparam int NEED_W = WW + 1 - PS;

  function automatic logic [PW-1:0] adv_page(input logic [PW-1:0] p,
                                             input logic [STEP_W-1:0] n);
    logic [PW:0] sum;
    sum = {1'b0, p} + (PW+1)'(n);
    return sum[PW] ? '0 : sum[PW-1:0];
  endfunction

  function automatic logic [WW-1:0] sat_add(input logic [WW-1:0] a,
                                            input logic [WW-1:0] b);
    logic [WW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[WW] ? '1 : sum[WW-1:0];
  endfunction

  nbbsr_pkg::state_t base;
  logic              checked;
  logic              run_cmd;
  logic              fail;
  logic [nbbsr_pkg::BAD_W-1:0] bad_inc;
  logic [WW-1:0]     take;

  logic [WW-1:0]     gap;
  logic [WW:0]       gap_round;
  logic [NEED_W-1:0] need;
  logic [STEP_W-1:0] left;
  logic [STEP_W-1:0] skip;
  logic [PW-1:0]     skip_page;
  logic [WW-1:0]     skip_logical;
  logic [PW-1:0]     cmd_page;
  nbbsr_pkg::action_t act;

  // request handling
  always_comb begin
    base    = cur;
    checked = 1'b0;
    run_cmd = 1'b0;
    fail    = 1'b0;
    bad_inc = cur.bad_count + 1'b1;
    take    = (cur.remaining_bytes < WW'(nbbsr_pkg::PAGE_BYTES)) ?
              cur.remaining_bytes : WW'(nbbsr_pkg::PAGE_BYTES);
    case (req_type)
      nbbsr_pkg::REQ_START: begin
        base.phys_page       = '0;
        base.logical_bytes   = '0;
        base.remaining_bytes = cfg.read_len;
        base.bad_count       = '0;
        base.dest_bytes      = '0;
        run_cmd              = 1'b1;
      end
      nbbsr_pkg::REQ_MARKER: begin
        if (cur.phase == nbbsr_pkg::PH_MARKER) begin
          if (marker_byte != nbbsr_pkg::ERASED_MARK) begin
            base.bad_count = bad_inc;
            if (bad_inc > {1'b0, cfg.max_bad_blocks}) begin
              fail = 1'b1;
            end else begin
              base.phys_page = adv_page(cur.phys_page,
                                        STEP_W'(nbbsr_pkg::PAGES_PER_BLOCK));
              run_cmd = 1'b1;
            end
          end else begin
            checked = 1'b1;
            run_cmd = 1'b1;
          end
        end
      end
      nbbsr_pkg::REQ_PAGE: begin
        if (cur.phase == nbbsr_pkg::PH_PAGE) begin
          base.phys_page       = adv_page(cur.phys_page, STEP_W'(1));
          base.logical_bytes   = sat_add(cur.logical_bytes,
                                         WW'(nbbsr_pkg::PAGE_BYTES));
          base.dest_bytes      = cur.dest_bytes + WW'(nbbsr_pkg::PAGE_BYTES);
          base.remaining_bytes = cur.remaining_bytes - take;
          run_cmd              = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // skip ahead toward the image offset, at most to the next block boundary
  always_comb begin
    gap          = cfg.image_offset - base.logical_bytes;
    gap_round    = {1'b0, gap} + (WW+1)'(nbbsr_pkg::PAGE_BYTES - 1);
    need         = gap_round[WW:PS];
    left         = STEP_W'(nbbsr_pkg::PAGES_PER_BLOCK) - {1'b0, base.phys_page[BS-1:0]};
    skip         = (need < NEED_W'(left)) ? need[STEP_W-1:0] : left;
    skip_page    = adv_page(base.phys_page, skip);
    skip_logical = sat_add(base.logical_bytes, WW'(skip) << PS);
  end

  always_comb begin
    nxt      = base;
    act      = nbbsr_pkg::ACT_IGNORED;
    cmd_page = base.phys_page;
    if (fail) begin
      nxt.phase = nbbsr_pkg::PH_IDLE;
      act       = nbbsr_pkg::ACT_FAIL;
    end else if (!run_cmd) begin
      act = nbbsr_pkg::ACT_IGNORED;
    end else if (base.remaining_bytes == '0) begin
      nxt.phase = nbbsr_pkg::PH_IDLE;
      act       = nbbsr_pkg::ACT_DONE;
    end else if (!checked && base.phys_page[BS-1:0] == '0) begin
      nxt.phase = nbbsr_pkg::PH_MARKER;
      act       = nbbsr_pkg::ACT_CHECK;
    end else if (base.logical_bytes < cfg.image_offset) begin
      nxt.phys_page     = skip_page;
      nxt.logical_bytes = skip_logical;
      cmd_page          = skip_page;
      if (skip_page[BS-1:0] == '0) begin
        nxt.phase = nbbsr_pkg::PH_MARKER;
        act       = nbbsr_pkg::ACT_CHECK;
      end else begin
        nxt.phase = nbbsr_pkg::PH_PAGE;
        act       = nbbsr_pkg::ACT_READ;
      end
    end else begin
      nxt.phase = nbbsr_pkg::PH_PAGE;
      act       = nbbsr_pkg::ACT_READ;
    end
  end

  always_comb begin
    res.action       = act;
    res.page_number  = (act == nbbsr_pkg::ACT_CHECK || act == nbbsr_pkg::ACT_READ) ?
                       cmd_page : '0;
    res.address_word = {res.page_number[15:0], 16'h0000};
    res.dest_offset  = (act == nbbsr_pkg::ACT_READ) ? base.dest_bytes : '0;
  end

endmodule

### rtl/nand_bad_block_skip_reader_core.sv
// Top level: NAND image reader that skips bad blocks, one command per request beat.
//
// Request channel (in_valid/in_ready): req_type 0 starts a read, 1 reports the
// marker byte of a block's first page, 2 reports a finished page read.
// Command channel (out_valid/out_ready): every request beat yields exactly one
// command beat: check marker, read page, done, failed, or ignored for a request
// that does not fit the current phase.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 image
// offset, 1 image size, 2 bad-block limit); write only while no read is active.
// The command register is loaded when a request is accepted; its command shows
// from the next cycle. Throughput is one request per cycle while the receiver
// takes commands; the whole step (counter update, offset skip, next command) is
// one combinational pass into the command register.
// A stalled receiver holds the command register; a new request is taken in
// the same cycle the held command leaves, so in_ready = !out_valid | out_ready.
// Reset clears the counters, sets the phase to idle, the limit to 16 and empties
// the command register.
module nand_bad_block_skip_reader_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  marker_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [20:0] page_number,
  output logic [31:0] address_word,
  output logic [31:0] dest_offset,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  nbbsr_pkg::cfg_t    cfg;
  nbbsr_pkg::state_t  st;
  nbbsr_pkg::state_t  st_next;
  nbbsr_pkg::result_t res;
  logic               in_beat;

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  nbbsr_step u_step (
    .cfg         (cfg),
    .cur         (st),
    .req_type    (req_type),
    .marker_byte (marker_byte),
    .nxt         (st_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_offset   <= '0;
      cfg.read_len       <= '0;
      cfg.max_bad_blocks <= nbbsr_pkg::MAX_BAD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nbbsr_pkg::CFG_IMAGE_OFFSET:   cfg.image_offset   <= cfg_data;
        nbbsr_pkg::CFG_READ_LEN:       cfg.read_len       <= cfg_data;
        nbbsr_pkg::CFG_MAX_BAD_BLOCKS:
          cfg.max_bad_blocks <= cfg_data[nbbsr_pkg::MAX_BAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phys_page       <= '0;
      st.logical_bytes   <= '0;
      st.remaining_bytes <= '0;
      st.bad_count       <= '0;
      st.dest_bytes      <= '0;
      st.phase           <= nbbsr_pkg::PH_IDLE;
      out_valid          <= 1'b0;
    end else begin
      if (in_beat) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      action       <= res.action;
      page_number  <= res.page_number;
      address_word <= res.address_word;
      dest_offset  <= res.dest_offset;
    end
  end

  a_marker_at_block_start: assert property (@(posedge clk) disable iff (rst)
    st.phase == nbbsr_pkg::PH_MARKER |-> st.phys_page[nbbsr_pkg::BLOCK_SHIFT-1:0] == '0)
    else $error("marker phase away from a block start");

  a_beat_gives_command: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no command");

  a_addr_matches_page: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> address_word == {page_number[15:0], 16'h0000})
    else $error("address word disagrees with page number");

  a_page_only_for_access: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != nbbsr_pkg::ACT_CHECK && action != nbbsr_pkg::ACT_READ
      |-> page_number == '0 && dest_offset == '0)
    else $error("page or offset on a non-access command");

  a_idle_after_end: assert property (@(posedge clk) disable iff (rst)
    in_beat && (res.action == nbbsr_pkg::ACT_DONE || res.action == nbbsr_pkg::ACT_FAIL)
      |=> st.phase == nbbsr_pkg::PH_IDLE)
    else $error("phase not idle after done or fail");

endmodule

### verif/nand_bad_block_skip_reader_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the bad-block skipping NAND reader: directed and random requests checked by a predictor.

class read_sequence_scoreboard;
  logic [nbbsr_pkg::WORD_W-1:0]    image_offset;
  logic [nbbsr_pkg::WORD_W-1:0]    read_len;
  logic [nbbsr_pkg::MAX_BAD_W-1:0] max_bad;
  logic [nbbsr_pkg::PAGE_W-1:0]    phys_page;
  logic [nbbsr_pkg::WORD_W-1:0]    logical_bytes;
  logic [nbbsr_pkg::WORD_W-1:0]    remaining_bytes;
  logic [nbbsr_pkg::BAD_W-1:0]     bad_count;
  logic [nbbsr_pkg::WORD_W-1:0]    dest_bytes;
  nbbsr_pkg::phase_t               phase;
  nbbsr_pkg::result_t              pending[$];
  int                              errors;
  int                              served;
  int                              act_count[8];

  function new();
    image_offset    = '0;
    read_len        = '0;
    max_bad         = nbbsr_pkg::MAX_BAD_RESET;
    phys_page       = '0;
    logical_bytes   = '0;
    remaining_bytes = '0;
    bad_count       = '0;
    dest_bytes      = '0;
    phase           = nbbsr_pkg::PH_IDLE;
    errors          = 0;
    served          = 0;
    foreach (act_count[i]) act_count[i] = 0;
  endfunction

  function void write_reg(logic [nbbsr_pkg::CFG_INDEX_W-1:0] idx,
                          logic [nbbsr_pkg::WORD_W-1:0] data);
    case (idx)
      nbbsr_pkg::CFG_IMAGE_OFFSET:   image_offset = data;
      nbbsr_pkg::CFG_READ_LEN:       read_len = data;
      nbbsr_pkg::CFG_MAX_BAD_BLOCKS: max_bad = data[nbbsr_pkg::MAX_BAD_W-1:0];
      default: ;
    endcase
  endfunction

  function nbbsr_pkg::result_t command(nbbsr_pkg::action_t act,
                                       logic [nbbsr_pkg::PAGE_W-1:0] pg,
                                       logic [nbbsr_pkg::WORD_W-1:0] dst);
    nbbsr_pkg::result_t r;
    r.action       = act;
    r.page_number  = (act == nbbsr_pkg::ACT_CHECK || act == nbbsr_pkg::ACT_READ) ?
                     pg : '0;
    r.address_word = nbbsr_pkg::WORD_W'({r.page_number, 16'h0000});
    r.dest_offset  = (act == nbbsr_pkg::ACT_READ) ? dst : '0;
    return r;
  endfunction

  // page counter wraps to zero past the last page of the device
  function void step_pages(longint unsigned n);
    longint unsigned nxt;
    nxt = phys_page + n;
    phys_page = (nxt >= (64'd1 << nbbsr_pkg::PAGE_W)) ? '0 : nxt[nbbsr_pkg::PAGE_W-1:0];
  endfunction

  function void add_logical(longint unsigned bytes);
    longint unsigned nxt;
    nxt = logical_bytes + bytes;
    logical_bytes = ((nxt >> nbbsr_pkg::WORD_W) != 0) ? '1 : nxt[nbbsr_pkg::WORD_W-1:0];
  endfunction

  function bit block_start();
    return phys_page[nbbsr_pkg::BLOCK_SHIFT-1:0] == '0;
  endfunction

  function nbbsr_pkg::result_t next_command(bit checked);
    longint unsigned gap, need, left, room, k;
    if (remaining_bytes == '0) begin
      phase = nbbsr_pkg::PH_IDLE;
      return command(nbbsr_pkg::ACT_DONE, '0, '0);
    end
    if (!checked && block_start()) begin
      phase = nbbsr_pkg::PH_MARKER;
      return command(nbbsr_pkg::ACT_CHECK, phys_page, '0);
    end
    if (logical_bytes < image_offset) begin
      // skip unread pages up to the offset, at most to the next block boundary
      gap  = image_offset - logical_bytes;
      need = (gap + nbbsr_pkg::PAGE_BYTES - 1) / nbbsr_pkg::PAGE_BYTES;
      left = nbbsr_pkg::PAGES_PER_BLOCK - phys_page[nbbsr_pkg::BLOCK_SHIFT-1:0];
      room = (64'd1 << nbbsr_pkg::PAGE_W) - phys_page;
      k = (need < left) ? need : left;
      if (k > room) k = room;
      step_pages(k);
      add_logical(k * nbbsr_pkg::PAGE_BYTES);
      if (block_start()) begin
        phase = nbbsr_pkg::PH_MARKER;
        return command(nbbsr_pkg::ACT_CHECK, phys_page, '0);
      end
    end
    phase = nbbsr_pkg::PH_PAGE;
    return command(nbbsr_pkg::ACT_READ, phys_page, dest_bytes);
  endfunction

  function void note_request(logic [1:0] req, logic [7:0] mark);
    nbbsr_pkg::result_t           r;
    logic [nbbsr_pkg::WORD_W-1:0] take;
    if (req == nbbsr_pkg::REQ_START) begin
      phys_page       = '0;
      logical_bytes   = '0;
      remaining_bytes = read_len;
      bad_count       = '0;
      dest_bytes      = '0;
      r = next_command(1'b0);
    end else if (req == nbbsr_pkg::REQ_MARKER && phase == nbbsr_pkg::PH_MARKER) begin
      if (mark != nbbsr_pkg::ERASED_MARK) begin
        bad_count = bad_count + 1'b1;
        if (bad_count > max_bad) begin
          phase = nbbsr_pkg::PH_IDLE;
          r = command(nbbsr_pkg::ACT_FAIL, '0, '0);
        end else begin
          step_pages(nbbsr_pkg::PAGES_PER_BLOCK);
          r = next_command(1'b0);
        end
      end else begin
        r = next_command(1'b1);
      end
    end else if (req == nbbsr_pkg::REQ_PAGE && phase == nbbsr_pkg::PH_PAGE) begin
      take = (remaining_bytes < nbbsr_pkg::PAGE_BYTES) ?
             remaining_bytes : nbbsr_pkg::PAGE_BYTES;
      step_pages(1);
      add_logical(nbbsr_pkg::PAGE_BYTES);
      dest_bytes      = dest_bytes + nbbsr_pkg::PAGE_BYTES;
      remaining_bytes = remaining_bytes - take;
      r = next_command(1'b0);
    end else begin
      r = command(nbbsr_pkg::ACT_IGNORED, '0, '0);
    end
    pending.push_back(r);
    act_count[r.action]++;
    if (r.action != nbbsr_pkg::ACT_IGNORED) served++;
  endfunction

  function void flag(string field, logic [nbbsr_pkg::WORD_W-1:0] want,
                     logic [nbbsr_pkg::WORD_W-1:0] seen);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, seen);
    errors++;
  endfunction

  function void check_command(logic [2:0] act, logic [nbbsr_pkg::PAGE_W-1:0] pg,
                              logic [nbbsr_pkg::WORD_W-1:0] aw,
                              logic [nbbsr_pkg::WORD_W-1:0] dst);
    nbbsr_pkg::result_t want;
    if (pending.size() == 0) begin
      $display("%0t: command beat with nothing expected, action %0h page %0h",
               $time, act, pg);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want.action !== act)
      flag("action", nbbsr_pkg::WORD_W'(want.action), nbbsr_pkg::WORD_W'(act));
    if (want.page_number !== pg)
      flag("page_number", nbbsr_pkg::WORD_W'(want.page_number), nbbsr_pkg::WORD_W'(pg));
    if (want.address_word !== aw) flag("address_word", want.address_word, aw);
    if (want.dest_offset !== dst) flag("dest_offset", want.dest_offset, dst);
  endfunction
endclass

module nand_bad_block_skip_reader_core_tb;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [1:0]        req_type = '0;
  logic [7:0]        marker_byte = '0;
  logic              out_ready = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [31:0]       cfg_data = '0;
  logic              in_ready;
  logic              out_valid;
  logic [2:0]        action;
  logic [20:0]       page_number;
  logic [31:0]       address_word;
  logic [31:0]       dest_offset;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  read_sequence_scoreboard sb;

  always #6 clk = ~clk;

  nand_bad_block_skip_reader_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .marker_byte  (marker_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .page_number  (page_number),
    .address_word (address_word),
    .dest_offset  (dest_offset),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  task automatic send(logic [1:0] req, logic [7:0] mark);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    marker_byte <= mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, mark);
  endtask

  // hold requests until every command beat has drained
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(logic [nbbsr_pkg::WORD_W-1:0] offset,
                              logic [nbbsr_pkg::WORD_W-1:0] size,
                              logic [nbbsr_pkg::MAX_BAD_W-1:0] limit);
    logic [nbbsr_pkg::WORD_W-1:0] junk;
    junk = $urandom;
    cfg_wr_en <= 1'b1;
    cfg_index <= nbbsr_pkg::CFG_IMAGE_OFFSET;
    cfg_data  <= offset;
    @(posedge clk);
    sb.write_reg(nbbsr_pkg::CFG_IMAGE_OFFSET, offset);
    cfg_index <= nbbsr_pkg::CFG_READ_LEN;
    cfg_data  <= size;
    @(posedge clk);
    sb.write_reg(nbbsr_pkg::CFG_READ_LEN, size);
    cfg_index <= nbbsr_pkg::CFG_MAX_BAD_BLOCKS;
    cfg_data  <= {junk[nbbsr_pkg::WORD_W-1:nbbsr_pkg::MAX_BAD_W], limit};
    @(posedge clk);
    sb.write_reg(nbbsr_pkg::CFG_MAX_BAD_BLOCKS,
                 {junk[nbbsr_pkg::WORD_W-1:nbbsr_pkg::MAX_BAD_W], limit});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_config();
    logic [nbbsr_pkg::WORD_W-1:0]    offset, size;
    logic [nbbsr_pkg::MAX_BAD_W-1:0] limit;
    case ($urandom_range(5))
      0: offset = '0;
      1: offset = $urandom_range(nbbsr_pkg::PAGE_BYTES * 8);
      2: offset = $urandom_range(nbbsr_pkg::PAGES_PER_BLOCK * nbbsr_pkg::PAGE_BYTES * 3);
      3: offset = '1;
      default: offset = $urandom;
    endcase
    case ($urandom_range(7))
      0: size = '0;
      1: size = '1;
      2: size = $urandom;
      default: size = $urandom_range(nbbsr_pkg::PAGE_BYTES * 6, 1);
    endcase
    case ($urandom_range(3))
      0: limit = '0;
      1: limit = '1;
      default: limit = nbbsr_pkg::MAX_BAD_W'($urandom_range(31));
    endcase
    write_config(offset, size, limit);
  endtask

  // finish the current read; spoiled markers force a fail once the bad-block limit is passed
  task automatic run_to_idle(bit spoil);
    while (sb.phase != nbbsr_pkg::PH_IDLE) begin
      if (sb.phase == nbbsr_pkg::PH_MARKER)
        send(nbbsr_pkg::REQ_MARKER, spoil ? 8'h00 : nbbsr_pkg::ERASED_MARK);
      else send(nbbsr_pkg::REQ_PAGE, 8'($urandom));
    end
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) send(2'($urandom_range(3)), 8'($urandom));
    else if (pick < 9 || sb.phase == nbbsr_pkg::PH_IDLE)
      send(nbbsr_pkg::REQ_START, 8'($urandom));
    else if (sb.phase == nbbsr_pkg::PH_MARKER)
      send(nbbsr_pkg::REQ_MARKER,
           ($urandom_range(3) != 0) ? nbbsr_pkg::ERASED_MARK : 8'($urandom));
    else send(nbbsr_pkg::REQ_PAGE, 8'($urandom));
    if ($urandom_range(99) < 2) settle();
  endtask

  initial forever begin
    @(posedge clk);
    if (!rst && out_valid && out_ready)
      sb.check_command(action, page_number, address_word, dest_offset);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int goal;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reports out of phase, then an empty image
    send(REQ_UNUSED, 8'hff);
    send(nbbsr_pkg::REQ_MARKER, nbbsr_pkg::ERASED_MARK);
    send(nbbsr_pkg::REQ_PAGE, 8'h00);
    send(nbbsr_pkg::REQ_START, 8'h00);
    settle();

    // short image with a partial last page, zero bad-block tolerance
    write_config('0, nbbsr_pkg::PAGE_BYTES + nbbsr_pkg::PAGE_BYTES / 2, '0);
    send(nbbsr_pkg::REQ_START, 8'h00);
    send(nbbsr_pkg::REQ_PAGE, 8'h00);
    send(nbbsr_pkg::REQ_MARKER, nbbsr_pkg::ERASED_MARK);
    send(nbbsr_pkg::REQ_MARKER, nbbsr_pkg::ERASED_MARK);
    send(nbbsr_pkg::REQ_PAGE, 8'hff);
    send(nbbsr_pkg::REQ_PAGE, 8'h00);
    send(nbbsr_pkg::REQ_START, 8'h00);
    send(nbbsr_pkg::REQ_MARKER, 8'h00);
    send(nbbsr_pkg::REQ_START, 8'h00);
    send(nbbsr_pkg::REQ_START, 8'hff);
    run_to_idle(1'b1);
    settle();

    // offset past three good blocks, one bad block on the way
    write_config(nbbsr_pkg::PAGES_PER_BLOCK * nbbsr_pkg::PAGE_BYTES * 3 + 5000, '1, '1);
    send(nbbsr_pkg::REQ_START, 8'h00);
    send(nbbsr_pkg::REQ_MARKER, nbbsr_pkg::ERASED_MARK);
    send(nbbsr_pkg::REQ_MARKER, 8'h7f);
    send(nbbsr_pkg::REQ_MARKER, nbbsr_pkg::ERASED_MARK);
    send(nbbsr_pkg::REQ_MARKER, nbbsr_pkg::ERASED_MARK);
    send(nbbsr_pkg::REQ_MARKER, nbbsr_pkg::ERASED_MARK);
    send(nbbsr_pkg::REQ_PAGE, 8'h55);
    send(nbbsr_pkg::REQ_PAGE, 8'haa);
    run_to_idle(1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 78 : 0;
      recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 33 : 0;
      for (int part = 0; part < 4; part++) begin
        settle();
        random_config();
        goal = sb.served + 95;
        while (sb.served < goal) random_request();
        run_to_idle(1'b1);
      end
    end

    // long offset: every block good, the skip crosses many block boundaries
    settle();
    write_config(nbbsr_pkg::PAGES_PER_BLOCK * nbbsr_pkg::PAGE_BYTES * 40 + 1,
                 nbbsr_pkg::PAGE_BYTES * 2, nbbsr_pkg::MAX_BAD_W'($urandom));
    send(nbbsr_pkg::REQ_START, 8'h00);
    run_to_idle(1'b0);

    in_valid <= 1'b0;
    for (int n = 0; n < 1000 && sb.pending.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected command beats never arrived", $time, sb.pending.size());
      sb.errors += sb.pending.size();
    end
    $display("%0d requests served and %0d ignored; %0d marker checks, %0d page reads",
             sb.served, sb.act_count[nbbsr_pkg::ACT_IGNORED],
             sb.act_count[nbbsr_pkg::ACT_CHECK], sb.act_count[nbbsr_pkg::ACT_READ]);
    $display("%0d reads completed, %0d failed on bad blocks, long offset skip run",
             sb.act_count[nbbsr_pkg::ACT_DONE], sb.act_count[nbbsr_pkg::ACT_FAIL]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("end of test: mismatches");
    $finish;
  end
endmodule
